/* design/cld_pkg.sv */
// Shared constants and interface types for the CPU load overload detector.
`default_nettype none

package cld_pkg;

  localparam int unsigned LOAD_W     = 7;
  localparam int unsigned TICK_W     = 64;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned HOLD_W     = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [LOAD_W-1:0] PCT_FULL    = 7'd100;
  localparam logic [LOAD_W-1:0] THRESH_RST  = 7'd90;
  localparam logic [HOLD_W-1:0] HOLDOFF_RST = 16'd20;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF   = 2'd1;

  typedef struct packed {
    logic start;  // compute a sample from the counters
    logic base;   // store the counters as the first baseline
  } cld_cmd_t;

  typedef struct packed {
    logic              done;
    logic [LOAD_W-1:0] load;
  } cld_res_t;

endpackage

`default_nettype wire

/* design/cld_load_calc.sv */
// Digit-serial counter delta and percent load unit (8-bit digits).
`default_nettype none

module cld_load_calc import cld_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cld_cmd_t          cmd_i,
  input  logic [TICK_W-1:0] total_i,
  input  logic [TICK_W-1:0] idle_i,
  output cld_res_t          res_o
);

  localparam int unsigned DIG_W  = 8;
  localparam int unsigned ACC_W  = TICK_W + DIG_W;
  localparam int unsigned NDIG   = ACC_W / DIG_W;
  localparam int unsigned TDIG   = TICK_W / DIG_W;
  localparam int unsigned CNT_W  = $clog2(NDIG);
  localparam int unsigned PASS_W = $clog2(LOAD_W);

  typedef enum logic [1:0] {L_IDLE, L_DELTA, L_DIV} lstate_e;

  lstate_e             state_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [PASS_W-1:0]   pass_q;
  logic                done_q;
  logic [LOAD_W-1:0]   load_q;
  logic [TICK_W-1:0]   pt_q, pi_q;   // previous counters
  logic [TICK_W-1:0]   dt_q, di_q;   // captured counters, then deltas
  logic [ACC_W-1:0]    t_q;          // running 2r + b*di
  logic                bt_q, bi_q, gb_q, nz_q;
  logic                rb_q, rm_q, ac_q, c1_q, c2_q, dm_q;
  logic [1:0]          k_q;
  logic [LOAD_W-1:0]   quo_q;

  logic [DIG_W:0]      sub_t, sub_i, sub_g, sub_r, add_t, cmp1, cmp2;
  logic [DIG_W-1:0]    ddig, idig, d2dig, kdig, r2dig;
  logic                last, bsel;
  logic [1:0]          kcur;
  logic [LOAD_W-1:0]   quo_n;

  // delta pass: total - prev, idle - prev, and the borrow of dt - di
  assign sub_t = {1'b0, dt_q[DIG_W-1:0]} - {1'b0, pt_q[DIG_W-1:0]} - {{DIG_W{1'b0}}, bt_q};
  assign sub_i = {1'b0, di_q[DIG_W-1:0]} - {1'b0, pi_q[DIG_W-1:0]} - {{DIG_W{1'b0}}, bi_q};
  assign sub_g = {1'b0, sub_t[DIG_W-1:0]} - {1'b0, sub_i[DIG_W-1:0]}
                 - {{DIG_W{1'b0}}, gb_q};

  // Horner pass over the bits of 100: t' = 2(t - k*dt) + b*di, k from t' vs dt, 2dt
  assign last  = (cnt_q == CNT_W'(NDIG - 1));
  assign ddig  = last ? '0 : dt_q[DIG_W-1:0];
  assign idig  = last ? '0 : di_q[DIG_W-1:0];
  assign d2dig = {ddig[DIG_W-2:0], dm_q};
  assign bsel  = PCT_FULL[PASS_W'(LOAD_W - 1) - pass_q];

  always_comb begin
    case (k_q)
      2'd1:    kdig = ddig;
      2'd2:    kdig = d2dig;
      default: kdig = '0;
    endcase
  end

  assign sub_r = {1'b0, t_q[DIG_W-1:0]} - {1'b0, kdig} - {{DIG_W{1'b0}}, rb_q};
  assign r2dig = {sub_r[DIG_W-2:0], rm_q};
  assign add_t = {1'b0, r2dig} + {1'b0, (bsel ? idig : {DIG_W{1'b0}})}
                 + {{DIG_W{1'b0}}, ac_q};
  assign cmp1  = {1'b0, add_t[DIG_W-1:0]} - {1'b0, ddig} - {{DIG_W{1'b0}}, c1_q};
  assign cmp2  = {1'b0, add_t[DIG_W-1:0]} - {1'b0, d2dig} - {{DIG_W{1'b0}}, c2_q};
  assign kcur  = !cmp2[DIG_W] ? 2'd2 : (!cmp1[DIG_W] ? 2'd1 : 2'd0);
  assign quo_n = {quo_q[LOAD_W-2:0], 1'b0} + LOAD_W'(kcur);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      cnt_q   <= '0;
      pass_q  <= '0;
      done_q  <= 1'b0;
      pt_q    <= '0;
      pi_q    <= '0;
    end else begin
      done_q <= (state_q == L_DIV) && last && (pass_q == PASS_W'(LOAD_W - 1));
      if (cmd_i.base) begin
        pt_q <= total_i;
        pi_q <= idle_i;
      end
      case (state_q)
        L_IDLE: begin
          if (cmd_i.start) begin
            state_q <= L_DELTA;
            cnt_q   <= '0;
          end
        end
        L_DELTA: begin
          // new total/idle digits replace the previous ones
          pt_q <= {dt_q[DIG_W-1:0], pt_q[TICK_W-1:DIG_W]};
          pi_q <= {di_q[DIG_W-1:0], pi_q[TICK_W-1:DIG_W]};
          if (cnt_q == CNT_W'(TDIG - 1)) begin
            state_q <= L_DIV;
            cnt_q   <= '0;
            pass_q  <= '0;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        L_DIV: begin
          if (last) begin
            cnt_q <= '0;
            if (pass_q == PASS_W'(LOAD_W - 1)) begin
              state_q <= L_IDLE;
            end else begin
              pass_q <= pass_q + 1'b1;
            end
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      L_IDLE: begin
        if (cmd_i.start) begin
          dt_q <= total_i;
          di_q <= idle_i;
          bt_q <= 1'b0;
          bi_q <= 1'b0;
          gb_q <= 1'b0;
          nz_q <= 1'b0;
        end
      end
      L_DELTA: begin
        dt_q  <= {sub_t[DIG_W-1:0], dt_q[TICK_W-1:DIG_W]};
        di_q  <= {sub_i[DIG_W-1:0], di_q[TICK_W-1:DIG_W]};
        bt_q  <= sub_t[DIG_W];
        bi_q  <= sub_i[DIG_W];
        gb_q  <= sub_g[DIG_W];
        nz_q  <= nz_q | (|sub_t[DIG_W-1:0]);
        t_q   <= '0;
        rb_q  <= 1'b0;
        rm_q  <= 1'b0;
        ac_q  <= 1'b0;
        c1_q  <= 1'b0;
        c2_q  <= 1'b0;
        dm_q  <= 1'b0;
        k_q   <= 2'd0;
        quo_q <= '0;
      end
      L_DIV: begin
        t_q <= {add_t[DIG_W-1:0], t_q[ACC_W-1:DIG_W]};
        if (last) begin
          rb_q  <= 1'b0;
          rm_q  <= 1'b0;
          ac_q  <= 1'b0;
          c1_q  <= 1'b0;
          c2_q  <= 1'b0;
          dm_q  <= 1'b0;
          k_q   <= kcur;
          quo_q <= quo_n;
          if (pass_q == PASS_W'(LOAD_W - 1)) begin
            // zero total delta or idle above total gives no load
            load_q <= (!nz_q || gb_q) ? '0 : PCT_FULL - quo_n;
          end
        end else begin
          dt_q <= {dt_q[DIG_W-1:0], dt_q[TICK_W-1:DIG_W]};
          di_q <= {di_q[DIG_W-1:0], di_q[TICK_W-1:DIG_W]};
          rb_q <= sub_r[DIG_W];
          rm_q <= sub_r[DIG_W-1];
          ac_q <= add_t[DIG_W];
          c1_q <= cmp1[DIG_W];
          c2_q <= cmp2[DIG_W];
          dm_q <= ddig[DIG_W-1];
        end
      end
      default: ;
    endcase
  end

  assign res_o.done = done_q;
  assign res_o.load = load_q;

endmodule

`default_nettype wire

/* design/cpu_load_overload_detector.sv */
// Top level: CPU load overload detector with trimmed-mean window.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------------------------
//  in      | input     | in_valid_i / in_ready_o   | now_seconds_i, total_ticks_i, idle_ticks_i
//  out     | output    | out_valid_o / out_ready_i | baseline_only_o, skipped_o, sample_load_o,
//          |           |                           | mean_load_o, overloaded_o
//  cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// A computed tick passes through 8 delta digits, then 7 passes of 9 digits in the serial percent
// divider of cld_load_calc, then a window scan of one entry a cycle and a restoring mean divider.
// Baseline and skipped ticks go straight to the output stage. Reset loads threshold 90 and hold-off 20.
// One tick at a time; a new tick is taken while the previous result waits on out.
`default_nettype none

module cpu_load_overload_detector import cld_pkg::*; #(
  parameter int unsigned WINDOW_LEN = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [TIME_W-1:0]     now_seconds_i,
  input  logic [TICK_W-1:0]     total_ticks_i,
  input  logic [TICK_W-1:0]     idle_ticks_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  baseline_only_o,
  output logic                  skipped_o,
  output logic [LOAD_W-1:0]     sample_load_o,
  output logic [LOAD_W-1:0]     mean_load_o,
  output logic                  overloaded_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned IDX_W  = $clog2(WINDOW_LEN);
  localparam int unsigned FILL_W = $clog2(WINDOW_LEN + 1);
  localparam int unsigned SUM_W  = $clog2(int'(PCT_FULL) * WINDOW_LEN + 1);
  localparam int unsigned DCNT_W = $clog2(SUM_W);

  typedef enum logic [2:0] {S_IDLE, S_CALC, S_SCAN, S_DIV, S_OUT} state_e;

  state_e              state_q;
  logic [LOAD_W-1:0]   thr_q;
  logic [HOLD_W-1:0]   hold_q;
  logic                primed_q, armed_q, flag_q;
  logic [TIME_W-1:0]   last_q, now_q;
  logic [IDX_W-1:0]    head_q, idx_q;
  logic [FILL_W-1:0]   fill_q, dsr_q;
  logic [SUM_W-1:0]    sum_q, dvd_q;
  logic [LOAD_W-1:0]   hi_q, lo_q;
  logic [FILL_W:0]     rem_q;
  logic [DCNT_W-1:0]   dcnt_q;
  logic                base_q, skip_q;
  logic [LOAD_W-1:0]   samp_q, mean_q;
  logic                out_valid_q, out_base_q, out_skip_q, out_flag_q;
  logic [LOAD_W-1:0]   out_samp_q, out_mean_q;
  logic [LOAD_W-1:0]   win_q [WINDOW_LEN];

  cld_cmd_t            calc_cmd;
  cld_res_t            calc_res;

  logic                in_fire, in_hold, scan_last, trim, div_ge;
  logic [TIME_W-1:0]   elapsed;
  logic [LOAD_W-1:0]   win_rd, hi_n, lo_n;
  logic [SUM_W-1:0]    sum_n, dvd_n, dvd_step;
  logic [FILL_W-1:0]   dsr_n;
  logic [FILL_W:0]     div_rs, rem_n;
  logic [IDX_W-1:0]    head_nx;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;

  assign elapsed = now_seconds_i - last_q;
  assign in_hold = armed_q && (elapsed < {{(TIME_W - HOLD_W){1'b0}}, hold_q});

  assign calc_cmd.base  = in_fire && !primed_q;
  assign calc_cmd.start = in_fire && primed_q && !in_hold;

  cld_load_calc u_calc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (calc_cmd),
    .total_i (total_ticks_i),
    .idle_i  (idle_ticks_i),
    .res_o   (calc_res)
  );

  // window scan, one entry a cycle
  assign win_rd    = win_q[idx_q];
  assign sum_n     = sum_q + SUM_W'(win_rd);
  assign hi_n      = (win_rd > hi_q) ? win_rd : hi_q;
  assign lo_n      = (win_rd < lo_q) ? win_rd : lo_q;
  assign scan_last = (idx_q == IDX_W'(fill_q - FILL_W'(1)));
  assign trim      = (fill_q >= FILL_W'(WINDOW_LEN - 1)) && (fill_q >= FILL_W'(3));
  assign dvd_n     = trim ? (sum_n - SUM_W'(hi_n) - SUM_W'(lo_n)) : sum_n;
  assign dsr_n     = trim ? (fill_q - FILL_W'(2)) : fill_q;
  assign head_nx   = (head_q == IDX_W'(WINDOW_LEN - 1)) ? '0 : head_q + 1'b1;

  // restoring divide of the window sum, one quotient bit a cycle
  assign div_rs   = {rem_q[FILL_W-1:0], dvd_q[SUM_W-1]};
  assign div_ge   = (div_rs >= {1'b0, dsr_q});
  assign rem_n    = div_ge ? (div_rs - {1'b0, dsr_q}) : div_rs;
  assign dvd_step = {dvd_q[SUM_W-2:0], div_ge};

  always_ff @(posedge clk_i) begin
    if (state_q == S_CALC && calc_res.done) begin
      win_q[head_q] <= calc_res.load;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      thr_q       <= THRESH_RST;
      hold_q      <= HOLDOFF_RST;
      primed_q    <= 1'b0;
      armed_q     <= 1'b0;
      flag_q      <= 1'b0;
      last_q      <= '0;
      now_q       <= '0;
      head_q      <= '0;
      fill_q      <= '0;
      idx_q       <= '0;
      sum_q       <= '0;
      hi_q        <= '0;
      lo_q        <= '1;
      dvd_q       <= '0;
      dsr_q       <= '0;
      rem_q       <= '0;
      dcnt_q      <= '0;
      base_q      <= 1'b0;
      skip_q      <= 1'b0;
      samp_q      <= '0;
      mean_q      <= '0;
      out_valid_q <= 1'b0;
      out_base_q  <= 1'b0;
      out_skip_q  <= 1'b0;
      out_samp_q  <= '0;
      out_mean_q  <= '0;
      out_flag_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_THRESHOLD: thr_q  <= cfg_data_i[LOAD_W-1:0];
          CFG_HOLDOFF:   hold_q <= cfg_data_i[HOLD_W-1:0];
          default: ;
        endcase
      end
      // in S_OUT the output register is reloaded below
      if (out_valid_q && out_ready_i && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            now_q  <= now_seconds_i;
            samp_q <= '0;
            mean_q <= '0;
            base_q <= !primed_q;
            skip_q <= primed_q && in_hold;
            if (!primed_q) begin
              primed_q <= 1'b1;
              state_q  <= S_OUT;
            end else if (in_hold) begin
              state_q <= S_OUT;
            end else begin
              state_q <= S_CALC;
            end
          end
        end
        S_CALC: begin
          if (calc_res.done) begin
            samp_q  <= calc_res.load;
            head_q  <= head_nx;
            if (fill_q < FILL_W'(WINDOW_LEN)) begin
              fill_q <= fill_q + 1'b1;
            end
            idx_q   <= '0;
            sum_q   <= '0;
            hi_q    <= '0;
            lo_q    <= '1;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          sum_q <= sum_n;
          hi_q  <= hi_n;
          lo_q  <= lo_n;
          if (scan_last) begin
            dvd_q   <= dvd_n;
            dsr_q   <= dsr_n;
            rem_q   <= '0;
            dcnt_q  <= DCNT_W'(SUM_W - 1);
            state_q <= S_DIV;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_DIV: begin
          dvd_q <= dvd_step;
          rem_q <= rem_n;
          if (dcnt_q == '0) begin
            mean_q <= dvd_step[LOAD_W-1:0];
            if (dvd_step[LOAD_W-1:0] >= thr_q) begin
              flag_q  <= 1'b1;
              last_q  <= now_q;
              armed_q <= 1'b1;
            end else begin
              flag_q <= 1'b0;
            end
            state_q <= S_OUT;
          end else begin
            dcnt_q <= dcnt_q - 1'b1;
          end
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_base_q  <= base_q;
            out_skip_q  <= skip_q;
            out_samp_q  <= samp_q;
            out_mean_q  <= mean_q;
            out_flag_q  <= flag_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign baseline_only_o = out_base_q;
  assign skipped_o       = out_skip_q;
  assign sample_load_o   = out_samp_q;
  assign mean_load_o     = out_mean_q;
  assign overloaded_o    = out_flag_q;

  a_done_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    calc_res.done |-> state_q == S_CALC)
    else $error("load unit finished outside the calc state");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(WINDOW_LEN))
    else $error("window fill beyond window length");

  a_kind_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(baseline_only_o && skipped_o))
    else $error("result both baseline and skipped");

  a_flag_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flag_q |-> armed_q)
    else $error("overload flag without hold-off armed");

  a_load_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (sample_load_o <= PCT_FULL) && (mean_load_o <= PCT_FULL))
    else $error("load result above full scale");

endmodule

`default_nettype wire

/* tb/cld_checker.sv */
// Checker for the CPU load overload detector: predicts each tick's result and compares it.
module cld_checker import cld_pkg::*; #(
  parameter int unsigned WIN_LEN = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [TIME_W-1:0]     now_seconds_i,
  input  logic [TICK_W-1:0]     total_ticks_i,
  input  logic [TICK_W-1:0]     idle_ticks_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic                  baseline_only_i,
  input  logic                  skipped_i,
  input  logic [LOAD_W-1:0]     sample_load_i,
  input  logic [LOAD_W-1:0]     mean_load_i,
  input  logic                  overloaded_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  drain_check_i,
  output int unsigned           pending_o,
  output int unsigned           failures_o
);

  typedef struct packed {
    logic              baseline;
    logic              skipped;
    logic [LOAD_W-1:0] sample;
    logic [LOAD_W-1:0] mean;
    logic              overloaded;
  } tick_result_t;

  // register copies
  logic [LOAD_W-1:0] threshold_q;
  logic [HOLD_W-1:0] holdoff_q;

  // predicted block state
  logic [TICK_W-1:0] last_total;
  logic [TICK_W-1:0] last_idle;
  logic              primed_q;
  logic [LOAD_W-1:0] window_q [WIN_LEN];
  int unsigned       window_count;
  int unsigned       window_wr;
  logic [TIME_W-1:0] overload_time;
  logic              holdoff_live;
  logic              overload_q;

  tick_result_t expected_results[$];
  tick_result_t want;
  tick_result_t got;

  int unsigned fail_count = 0;
  int unsigned n_base = 0;
  int unsigned n_skip = 0;
  int unsigned n_computed = 0;
  int unsigned n_overload = 0;
  logic        summary_done = 1'b0;

  // load as 100 minus the idle share of the counter delta, exact at full width
  function automatic logic [LOAD_W-1:0] load_percent(input logic [TICK_W-1:0] dt,
                                                     input logic [TICK_W-1:0] di);
    logic [TICK_W+7:0] idle_pct;
    if (dt == '0 || di > dt) return '0;
    idle_pct = ({8'd0, di} * 100) / {8'd0, dt};
    return PCT_FULL - idle_pct[LOAD_W-1:0];
  endfunction

  function automatic logic [LOAD_W-1:0] window_mean(input logic [LOAD_W-1:0] load);
    int unsigned sum;
    int unsigned hi;
    int unsigned lo;
    int unsigned avg;
    int unsigned i;
    sum = 0;
    hi = 0;
    lo = 127;
    window_q[window_wr] = load;
    window_wr = (window_wr + 1) % WIN_LEN;
    if (window_count < WIN_LEN) window_count++;
    for (i = 0; i < window_count; i++) begin
      sum += window_q[i];
      if (window_q[i] > hi) hi = window_q[i];
      if (window_q[i] < lo) lo = window_q[i];
    end
    // extremes are dropped once the window is nearly full
    if (window_count >= WIN_LEN - 1 && window_count >= 3)
      avg = (sum - hi - lo) / (window_count - 2);
    else
      avg = sum / window_count;
    return avg[LOAD_W-1:0];
  endfunction

  function automatic tick_result_t compute_tick_result(input logic [TIME_W-1:0] now,
                                                       input logic [TICK_W-1:0] total,
                                                       input logic [TICK_W-1:0] idle);
    tick_result_t r;
    logic [TIME_W-1:0] age;
    r = '0;
    age = now - overload_time;
    if (!primed_q) begin
      last_total = total;
      last_idle = idle;
      primed_q = 1'b1;
      r.baseline = 1'b1;
    end else if (holdoff_live && age < holdoff_q) begin
      r.skipped = 1'b1;
    end else begin
      r.sample = load_percent(total - last_total, idle - last_idle);
      last_total = total;
      last_idle = idle;
      r.mean = window_mean(r.sample);
      if (r.mean >= threshold_q) begin
        overload_q = 1'b1;
        overload_time = now;
        holdoff_live = 1'b1;
      end else begin
        overload_q = 1'b0;
      end
    end
    r.overloaded = overload_q;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [LOAD_W-1:0] exp_val,
                             input logic [LOAD_W-1:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %0d, got %0d", field, exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q = THRESH_RST;
      holdoff_q = HOLDOFF_RST;
      last_total = '0;
      last_idle = '0;
      primed_q = 1'b0;
      for (int k = 0; k < WIN_LEN; k++) window_q[k] = '0;
      window_count = 0;
      window_wr = 0;
      overload_time = '0;
      holdoff_live = 1'b0;
      overload_q = 1'b0;
      expected_results.delete();
      pending_o <= 0;
      failures_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with no tick outstanding");
          fail_count++;
        end else begin
          // oldest outstanding tick sits at the head
          want = expected_results[0];
          expected_results.delete(0);
          got = '{baseline_only_i, skipped_i, sample_load_i, mean_load_i, overloaded_i};
          check_field("baseline_only", want.baseline, got.baseline);
          check_field("skipped", want.skipped, got.skipped);
          check_field("sample_load", want.sample, got.sample);
          check_field("mean_load", want.mean, got.mean);
          check_field("overloaded", want.overloaded, got.overloaded);
        end
      end
      if (in_valid_i && in_ready_i) begin
        want = compute_tick_result(now_seconds_i, total_ticks_i, idle_ticks_i);
        expected_results.insert(expected_results.size(), want);
        if (want.baseline) n_base++;
        else if (want.skipped) n_skip++;
        else n_computed++;
        if (!want.baseline && !want.skipped && want.overloaded) n_overload++;
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_THRESHOLD) threshold_q = cfg_data_i[LOAD_W-1:0];
        else if (cfg_index_i == CFG_HOLDOFF) holdoff_q = cfg_data_i[HOLD_W-1:0];
      end
      if (drain_check_i && !summary_done) begin
        summary_done = 1'b1;
        if (expected_results.size() != 0) begin
          $error("%0d tick results never arrived", expected_results.size());
          fail_count++;
        end
        $display("ticks seen: %0d baseline, %0d computed (%0d overloads), %0d in hold-off",
                 n_base, n_computed, n_overload, n_skip);
      end
      pending_o <= expected_results.size();
      failures_o <= fail_count;
    end
  end

endmodule

/* tb/tb.sv */
// Testbench top: drives ticks and register writes into the overload detector, gives the verdict.
module tb import cld_pkg::*; ();

  localparam int unsigned LONG_HOLD   = 600;
  localparam int unsigned DRAIN_WAIT  = 100;
  localparam int unsigned STALL_LIMIT = 3000;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [TIME_W-1:0]     now_s = '0;
  logic [TICK_W-1:0]     total = '0;
  logic [TICK_W-1:0]     idle = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  baseline_only;
  logic                  skipped;
  logic [LOAD_W-1:0]     sample_load;
  logic [LOAD_W-1:0]     mean_load;
  logic                  overloaded;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic        drain_check = 1'b0;
  int unsigned pending;
  int unsigned failures;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned stall_req = 0;
  int unsigned stall_ack = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  logic [TIME_W-1:0] cur_now = '0;
  logic [TICK_W-1:0] cur_total = '0;
  logic [TICK_W-1:0] cur_idle = '0;
  bit                busy = 1'b0;
  int unsigned       ticks_sent = 0;
  int unsigned       settings_used = 1;

  always #5 clk = ~clk;

  cpu_load_overload_detector dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .now_seconds_i  (now_s),
    .total_ticks_i  (total),
    .idle_ticks_i   (idle),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .baseline_only_o(baseline_only),
    .skipped_o      (skipped),
    .sample_load_o  (sample_load),
    .mean_load_o    (mean_load),
    .overloaded_o   (overloaded),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  cld_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .now_seconds_i  (now_s),
    .total_ticks_i  (total),
    .idle_ticks_i   (idle),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .baseline_only_i(baseline_only),
    .skipped_i      (skipped),
    .sample_load_i  (sample_load),
    .mean_load_i    (mean_load),
    .overloaded_i   (overloaded),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .drain_check_i  (drain_check),
    .pending_o      (pending),
    .failures_o     (failures)
  );

  // result side: random back-pressure, plus a long hold when requested
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (stall_req != stall_ack) begin
      stall_ack <= stall_req;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99, 0) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("cpu_load_overload_detector regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_tick();
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    now_s <= cur_now;
    total <= cur_total;
    idle <= cur_idle;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ticks_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [CFG_DATA_W-1:0] thr, input logic [CFG_DATA_W-1:0] hold);
    wait_drained();
    write_reg(CFG_THRESHOLD, thr);
    if ($urandom_range(1, 0)) write_reg(CFG_SPARE_A, CFG_DATA_W'($urandom));
    write_reg(CFG_HOLDOFF, hold);
    if ($urandom_range(1, 0)) write_reg(CFG_SPARE_B, CFG_DATA_W'($urandom));
    settings_used++;
  endtask

  task automatic tick(input logic [TIME_W-1:0] step, input logic [TICK_W-1:0] dt,
                      input logic [TICK_W-1:0] di);
    cur_now += step;
    cur_total += dt;
    cur_idle += di;
    send_tick();
  endtask

  task automatic random_tick(input bit long_steps);
    int unsigned       kind;
    int unsigned       load;
    logic [TIME_W-1:0] step;
    logic [TICK_W-1:0] dt;
    logic [TICK_W-1:0] di;
    logic [TICK_W+7:0] wide;
    if ($urandom_range(9, 0) == 0) busy = !busy;
    kind = $urandom_range(99, 0);
    if (long_steps && $urandom_range(1, 0)) step = $urandom_range(140000, 60000);
    else if ($urandom_range(19, 0) == 0) step = $urandom;
    else step = $urandom_range(3, 0);
    if (kind < 4) begin
      // counters reloaded at random: arbitrary wrapped deltas
      cur_now += step;
      cur_total = {$urandom, $urandom};
      cur_idle = {$urandom, $urandom};
      send_tick();
    end else if (kind < 7) begin
      tick(step, '0, TICK_W'($urandom_range(5, 0)));
    end else if (kind < 10) begin
      dt = TICK_W'($urandom_range(1000, 1));
      tick(step, dt, dt + TICK_W'($urandom_range(50, 1)));
    end else begin
      if (busy) load = ($urandom_range(2, 0) == 0) ? 100 : $urandom_range(100, 80);
      else load = $urandom_range(100, 0);
      case ($urandom_range(9, 0))
        0: dt = TICK_W'($urandom_range(3, 1));
        7: dt = {$urandom, $urandom} >> $urandom_range(63, 1);
        8: dt = {$urandom, $urandom};
        default: dt = TICK_W'($urandom_range(100000, 100));
      endcase
      if (dt == '0) dt = TICK_W'(1);
      wide = {8'd0, dt} * (100 - load);
      di = TICK_W'(wide / 100);
      tick(step, dt, di);
    end
  endtask

  task automatic run_phase(input int unsigned n, input logic [CFG_DATA_W-1:0] thr,
                           input logic [CFG_DATA_W-1:0] hold, input int unsigned tx_pct,
                           input int unsigned rx_pct, input bit long_steps,
                           input bit long_hold, input bit pause);
    int unsigned i;
    set_regs(thr, hold);
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
    for (i = 0; i < n; i++) begin
      if (i == n / 2 && long_hold) stall_req <= stall_req + 1;
      if (i == n / 2 && pause) wait_drained();
      random_tick(long_steps);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: baseline, hold-off edges, zero and inverted deltas, wrap, trimming
    cur_total = 64'hFFFF_FFFF_FFFF_FF00;
    cur_idle = 64'hFFFF_FFFF_FFFF_FFF0;
    send_tick();
    tick(32'd1, 64'h200, '0);
    tick(32'd19, '0, '0);
    tick(32'd1, '0, 64'd3);
    tick(32'd1, 64'd10, 64'd11);
    tick(32'd1, 64'd10, 64'd10);
    tick(32'd1, 64'hFFFF_FFFF_FFFF_FFFF, '0);
    tick(32'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE);
    tick(32'd1, 64'd200, 64'd100);
    tick(32'd1, 64'd3, 64'd1);
    repeat (4) tick(32'd1, 64'd1000, '0);
    tick(32'd3, 64'd1000, '0);
    tick(32'hFFFF_FFF0 - cur_now, 64'd1000, '0);
    tick(32'd32, 64'd500, 64'd250);
    tick(32'd5, 64'd500, '0);
    // threshold field takes the low bits only: this sets it to zero
    set_regs(16'hFF80, 16'd0);
    tick('0, '0, '0);
    tick('0, 64'd100, 64'd100);
    set_regs(16'hFFFF, 16'hFFFF);
    tick(32'd70000, 64'd100, '0);
    tick(32'd1, 64'd100, '0);

    run_phase(280, 16'd85, 16'd10, 11, 83, 1'b0, 1'b1, 1'b0);
    run_phase(200, 16'hFF80, 16'd0, 11, 83, 1'b0, 1'b0, 1'b0);
    run_phase(150, 16'd100, 16'hFFFF, 83, 11, 1'b1, 1'b0, 1'b0);
    run_phase(200, 16'hFFFF, 16'd5, 83, 11, 1'b0, 1'b0, 1'b0);
    run_phase(300, 16'd60, 16'd3, 0, 0, 1'b0, 1'b0, 1'b1);
    run_phase(300, 16'd95, 16'd30, 0, 0, 1'b0, 1'b0, 1'b0);
    run_phase(200, 16'd1, 16'd1, 0, 0, 1'b0, 1'b0, 1'b0);

    wait_drained();
    drain_check <= 1'b1;
    repeat (3) @(posedge clk);
    $display("%0d ticks over %0d register settings, with back-pressure on each side and none",
             ticks_sent, settings_used);
    if (failures == 0) begin
      $display("cpu_load_overload_detector regression: pass");
    end else begin
      $display("cpu_load_overload_detector regression: fail");
    end
    $finish;
  end

endmodule
